@@ rtl/alt_svc_header_parser_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the alternative-service header parser.
// ---------------------------------------------------------------------------
`ifndef ALT_SVC_HEADER_PARSER_ASSERT_SVH
`define ALT_SVC_HEADER_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASH_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ash_pkg.sv @@
// ---------------------------------------------------------------------------
// ash_pkg
// Shared types, phase codes and character helpers of the header parser.
// ---------------------------------------------------------------------------
`default_nettype none

package ash_pkg;

   // Parse phases.
   localparam logic [3:0] PH_PROTO_START   = 4'd0;
   localparam logic [3:0] PH_PROTO         = 4'd1;
   localparam logic [3:0] PH_AUTH_OPEN     = 4'd2;
   localparam logic [3:0] PH_AUTH_FIRST    = 4'd3;
   localparam logic [3:0] PH_HOST          = 4'd4;
   localparam logic [3:0] PH_AFTER_BRACKET = 4'd5;
   localparam logic [3:0] PH_PORT          = 4'd6;
   localparam logic [3:0] PH_PARAM_SEP     = 4'd7;
   localparam logic [3:0] PH_NAME_WS       = 4'd8;
   localparam logic [3:0] PH_NAME          = 4'd9;
   localparam logic [3:0] PH_AFTER_NAME    = 4'd10;
   localparam logic [3:0] PH_VAL_WS        = 4'd11;
   localparam logic [3:0] PH_MA            = 4'd12;
   localparam logic [3:0] PH_V_LIST        = 4'd13;
   localparam logic [3:0] PH_SKIP_VAL      = 4'd14;
   localparam logic [3:0] PH_ENTRY_SEP     = 4'd15;

   // Parameter name match codes.
   localparam logic [2:0] PM_EMPTY = 3'd0;
   localparam logic [2:0] PM_M     = 3'd1;
   localparam logic [2:0] PM_MA    = 3'd2;
   localparam logic [2:0] PM_V     = 3'd3;
   localparam logic [2:0] PM_OTHER = 3'd4;

   // Clear word match: five characters matched, or no match possible.
   localparam logic [2:0] CM_DONE = 3'd5;
   localparam logic [2:0] CM_FAIL = 3'd7;

   // Result kinds.
   localparam logic [2:0] KIND_PROTO   = 3'd0;
   localparam logic [2:0] KIND_HOST    = 3'd1;
   localparam logic [2:0] KIND_PORT    = 3'd2;
   localparam logic [2:0] KIND_VERSION = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;
   localparam logic [2:0] KIND_STATUS  = 3'd5;

   // Status values.
   localparam logic [31:0] STATUS_OK    = 32'd0;
   localparam logic [31:0] STATUS_CLEAR = 32'd1;
   localparam logic [31:0] STATUS_ERROR = 32'd2;

   localparam logic [31:0] DEFAULT_MAX_AGE = 32'd86400;
   localparam logic [35:0] PORT_LIMIT      = 36'd65535;
   localparam logic [35:0] MA_LIMIT        = 36'hFFFFFFFF;

   // Parser state carried from one item to the next.
   typedef struct packed {
      logic [3:0]  phase;
      logic [31:0] acc;
      logic        hex_open;
      logic        hex_have;
      logic [3:0]  hex_val;
      logic [2:0]  pm;
      logic [31:0] ema;
      logic [2:0]  cm;
      logic        err;
      logic        esc;
      logic        bracket;
      logic        ma;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase: PH_PROTO_START, acc: 32'd0, hex_open: 1'b0, hex_have: 1'b0,
      hex_val: 4'd0, pm: PM_EMPTY, ema: 32'd0, cm: 3'd0, err: 1'b0,
      esc: 1'b0, bracket: 1'b0, ma: 1'b0};

   // Up to three results produced by one item.
   typedef struct packed {
      logic [1:0]        count;
      logic [2:0][2:0]   kind;
      logic [2:0][31:0]  value;
   } result_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   // Hex digit value; bit 4 set marks a non-hex byte.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [7:0] d;
      d = 8'd0;
      if (is_digit(b)) d = b - 8'h30;
      else if (b >= 8'h61 && b <= 8'h66) d = b - 8'h57;
      else if (b >= 8'h41 && b <= 8'h46) d = b - 8'h37;
      else d = 8'd16;
      return d[4:0];
   endfunction

   // Case-insensitive match of the parameter names ma and v.
   function automatic logic [2:0] name_next(input logic [2:0] m, input logic [7:0] b);
      logic [7:0] c;
      logic [2:0] r;
      c = b;
      if (b >= 8'h41 && b <= 8'h5A) c = b + 8'd32;
      if (m == PM_EMPTY) r = (c == 8'h6D) ? PM_M : ((c == 8'h76) ? PM_V : PM_OTHER);
      else if (m == PM_M && c == 8'h61) r = PM_MA;
      else r = PM_OTHER;
      return r;
   endfunction

   // Characters of the word clear.
   function automatic logic [7:0] clear_char(input logic [2:0] i);
      logic [7:0] c;
      unique case (i)
         3'd0: c = 8'h63;
         3'd1: c = 8'h6C;
         3'd2: c = 8'h65;
         3'd3: c = 8'h61;
         3'd4: c = 8'h72;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ash_channels_if.sv @@
// ---------------------------------------------------------------------------
// ash_req_if / ash_rsp_if
// Valid/ready channels for header bytes in and tokens out.
// ---------------------------------------------------------------------------
`default_nettype none

interface ash_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ash_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  out_kind;
   logic [31:0] out_value;
   logic        out_last;

   modport source (output valid, output out_kind, output out_value, output out_last,
                   input ready);
   modport sink   (input valid, input out_kind, input out_value, input out_last,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/ash_step.sv @@
// ---------------------------------------------------------------------------
// ash_step
// Next-state and token logic for one header byte.
// ---------------------------------------------------------------------------
`default_nettype none

module ash_step (
   input  ash_pkg::state_type  state_cur,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   input  logic [31:0]         default_max_age,
   output ash_pkg::state_type  state_nxt,
   output ash_pkg::result_type result
);
   import ash_pkg::*;

   always_comb begin
      state_type  s;
      state_type  t;
      result_type r;
      logic [7:0] b;
      logic [1:0] n;
      logic       do_proto;
      logic       do_host;
      logic       do_end;
      logic       esc;
      logic [4:0] h;
      logic [35:0] acc10;
      logic [35:0] limit;

      s = state_cur;
      t = s;
      r = '0;
      b = in_byte;
      n = 2'd0;
      do_proto = 1'b0;
      do_host = 1'b0;
      do_end = 1'b0;
      esc = 1'b0;
      h = hex_value(b);
      acc10 = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + {32'd0, b[3:0]};
      limit = (s.phase == PH_MA) ? MA_LIMIT : PORT_LIMIT;

      // Track whether the value so far spells clear.
      if (s.cm < CM_DONE && b == clear_char(s.cm)) t.cm = s.cm + 3'd1;
      else t.cm = CM_FAIL;

      if (in_last && t.cm == CM_DONE) begin
         r.kind[n] = KIND_STATUS; r.value[n] = STATUS_CLEAR; n = n + 2'd1;
      end else begin
         // Phase dispatch for the byte.
         if (!s.err) begin
            unique case (s.phase)
               PH_PROTO_START, PH_PROTO: begin
                  do_proto = 1'b1;
               end
               PH_AUTH_OPEN: begin
                  if (b == 8'h22) t.phase = PH_AUTH_FIRST;
                  else t.err = 1'b1;
               end
               PH_AUTH_FIRST: begin
                  t.phase = PH_HOST;
                  if (b == 8'h5B) begin
                     t.bracket = 1'b1;
                     r.kind[n] = KIND_HOST; r.value[n] = {24'd0, b}; n = n + 2'd1;
                  end else begin
                     do_host = 1'b1;
                  end
               end
               PH_HOST: begin
                  do_host = 1'b1;
               end
               PH_AFTER_BRACKET: begin
                  if (b == 8'h3A) begin
                     t.acc = 32'd0; t.phase = PH_PORT;
                  end else begin
                     t.err = 1'b1;
                  end
               end
               PH_PORT, PH_V_LIST: begin
                  if (is_digit(b)) begin
                     if (acc10 > limit) t.err = 1'b1;
                     else t.acc = acc10[31:0];
                  end else if (s.phase == PH_PORT && b == 8'h22 && s.acc != 32'd0) begin
                     r.kind[n] = KIND_PORT; r.value[n] = s.acc; n = n + 2'd1;
                     t.phase = PH_PARAM_SEP;
                  end else if (s.phase == PH_V_LIST && (b == 8'h2C || b == 8'h22) &&
                               s.acc != 32'd0) begin
                     r.kind[n] = KIND_VERSION; r.value[n] = s.acc; n = n + 2'd1;
                     t.acc = 32'd0;
                     if (b == 8'h22) t.phase = PH_PARAM_SEP;
                  end else begin
                     t.err = 1'b1;
                  end
               end
               PH_PARAM_SEP: begin
                  if (is_ws(b)) t.phase = s.phase;
                  else if (b == 8'h3B) t.phase = PH_NAME_WS;
                  else if (b == 8'h2C) do_end = 1'b1;
                  else t.err = 1'b1;
               end
               PH_NAME_WS: begin
                  if (is_ws(b)) t.phase = s.phase;
                  else if (b == 8'h2C) do_end = 1'b1;
                  else if (b == 8'h3D) begin
                     t.pm = PM_EMPTY; t.phase = PH_VAL_WS;
                  end else begin
                     t.pm = name_next(PM_EMPTY, b); t.phase = PH_NAME;
                  end
               end
               PH_NAME: begin
                  if (is_ws(b)) t.phase = PH_AFTER_NAME;
                  else if (b == 8'h3D) t.phase = PH_VAL_WS;
                  else if (b == 8'h2C) t.err = 1'b1;
                  else t.pm = name_next(s.pm, b);
               end
               PH_AFTER_NAME: begin
                  if (is_ws(b)) t.phase = s.phase;
                  else if (b == 8'h3D) t.phase = PH_VAL_WS;
                  else t.err = 1'b1;
               end
               PH_VAL_WS: begin
                  if (is_ws(b)) t.phase = s.phase;
                  else if (b == 8'h3B || b == 8'h2C) t.err = 1'b1;
                  else if (s.pm == PM_MA) begin
                     if (is_digit(b)) begin
                        t.acc = {28'd0, b[3:0]}; t.phase = PH_MA;
                     end else begin
                        t.err = 1'b1;
                     end
                  end else if (s.pm == PM_V) begin
                     if (b == 8'h22) begin
                        t.acc = 32'd0; t.phase = PH_V_LIST;
                     end else begin
                        t.err = 1'b1;
                     end
                  end else begin
                     t.phase = PH_SKIP_VAL;
                  end
               end
               PH_MA: begin
                  if (is_digit(b)) begin
                     if (acc10 > limit) t.err = 1'b1;
                     else t.acc = acc10[31:0];
                  end else if (is_ws(b) || b == 8'h3B || b == 8'h2C) begin
                     // Commit the max age.
                     if (s.acc == 32'd0) t.err = 1'b1;
                     else begin
                        t.ema = s.acc; t.ma = 1'b1;
                     end
                     if (is_ws(b)) t.phase = PH_PARAM_SEP;
                     else if (b == 8'h3B) t.phase = PH_NAME_WS;
                     else if (!t.err) do_end = 1'b1;
                  end else begin
                     t.err = 1'b1;
                  end
               end
               PH_SKIP_VAL: begin
                  if (is_ws(b)) t.phase = PH_PARAM_SEP;
                  else if (b == 8'h3B) t.phase = PH_NAME_WS;
                  else if (b == 8'h2C) do_end = 1'b1;
               end
               PH_ENTRY_SEP: begin
                  if (!(is_ws(b) || b == 8'h2C)) begin
                     t.phase = PH_PROTO_START;
                     do_proto = 1'b1;
                  end
               end
               default: begin
                  t.err = 1'b1;
               end
            endcase
         end

         // Protocol-id byte with percent decoding.
         if (do_proto) begin
            if (t.hex_open) begin
               if (h[4]) t.err = 1'b1;
               else if (t.hex_have) begin
                  r.kind[n] = KIND_PROTO; r.value[n] = {24'd0, t.hex_val, h[3:0]};
                  n = n + 2'd1;
                  t.hex_open = 1'b0; t.hex_have = 1'b0; t.hex_val = 4'd0;
               end else begin
                  t.hex_have = 1'b1; t.hex_val = h[3:0];
               end
            end else if (b == 8'h3D) begin
               if (t.phase == PH_PROTO_START) t.err = 1'b1;
               else t.phase = PH_AUTH_OPEN;
            end else begin
               t.phase = PH_PROTO;
               if (b == 8'h25) t.hex_open = 1'b1;
               else begin
                  r.kind[n] = KIND_PROTO; r.value[n] = {24'd0, b}; n = n + 2'd1;
               end
            end
         end

         // Host byte: bracketed hosts verbatim, others backslash-unescaped.
         if (do_host) begin
            esc = s.esc;
            t.esc = 1'b0;
            if (t.bracket) begin
               if (b == 8'h22) t.err = 1'b1;
               else begin
                  r.kind[n] = KIND_HOST; r.value[n] = {24'd0, b}; n = n + 2'd1;
                  if (b == 8'h5D) t.phase = PH_AFTER_BRACKET;
                  else if (b == 8'h5C && !esc) t.esc = 1'b1;
               end
            end else if (esc) begin
               r.kind[n] = KIND_HOST; r.value[n] = {24'd0, b}; n = n + 2'd1;
            end else if (b == 8'h22) t.err = 1'b1;
            else if (b == 8'h5C) t.esc = 1'b1;
            else if (b == 8'h3A) begin
               t.acc = 32'd0; t.phase = PH_PORT;
            end else begin
               r.kind[n] = KIND_HOST; r.value[n] = {24'd0, b}; n = n + 2'd1;
            end
         end

         // Entry end token.
         if (do_end) begin
            r.kind[n] = KIND_END;
            r.value[n] = t.ma ? t.ema : default_max_age;
            n = n + 2'd1;
            t.ma = 1'b0; t.phase = PH_ENTRY_SEP;
         end

         if (t.err) n = 2'd0;

         // End of the header value.
         if (in_last) begin
            if (!t.err) begin
               do_end = 1'b0;
               priority case (t.phase)
                  PH_PARAM_SEP, PH_NAME_WS, PH_SKIP_VAL: do_end = 1'b1;
                  PH_MA: begin
                     if (t.acc == 32'd0) t.err = 1'b1;
                     else begin
                        t.ema = t.acc; t.ma = 1'b1; do_end = 1'b1;
                     end
                  end
                  PH_ENTRY_SEP: do_end = 1'b0;
                  default: t.err = 1'b1;
               endcase
               if (do_end) begin
                  r.kind[n] = KIND_END;
                  r.value[n] = t.ma ? t.ema : default_max_age;
                  n = n + 2'd1;
               end
               if (!t.err) begin
                  r.kind[n] = KIND_STATUS; r.value[n] = STATUS_OK; n = n + 2'd1;
               end
            end
            if (t.err) begin
               n = 2'd0;
               r.kind[n] = KIND_STATUS; r.value[n] = STATUS_ERROR; n = n + 2'd1;
            end
         end
      end

      // A finished value returns the parser to its start.
      if (in_last) t = STATE_RESET;

      r.count = n;
      state_nxt = t;
      result = r;
   end

endmodule

`default_nettype wire

@@ rtl/ash_rsp_queue.sv @@
// ---------------------------------------------------------------------------
// ash_rsp_queue
// Result register holding the tokens of one item and sending them in order.
// ---------------------------------------------------------------------------
`default_nettype none

module ash_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ash_pkg::result_type load_data,
   output logic                can_load,
   ash_rsp_if.source           rsp_ch
);
   import ash_pkg::*;

   logic [1:0]  cnt_ff, cnt_in;
   logic [1:0]  rd_ff, rd_in;
   result_type  buf_ff, buf_in;
   logic        pop;

   assign pop = rsp_ch.valid && rsp_ch.ready;

   // A new item may enter once the last waiting token leaves this cycle.
   assign can_load = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ch.ready);

   assign rsp_ch.valid     = (cnt_ff != 2'd0);
   assign rsp_ch.out_kind  = buf_ff.kind[rd_ff];
   assign rsp_ch.out_value = buf_ff.value[rd_ff];
   assign rsp_ch.out_last  = (cnt_ff == 2'd1);

   // Load replaces the drained contents, otherwise step through them.
   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      buf_in = buf_ff;
      if (load) begin
         cnt_in = load_data.count;
         rd_in  = 2'd0;
         buf_in = load_data;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         rd_in  = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

`default_nettype wire

@@ rtl/alt_svc_header_parser.sv @@
// ---------------------------------------------------------------------------
// alt_svc_header_parser
// Streaming parser of an alternative-service header value into tokens.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one byte of the header value per item, with in_last on the
//   final byte. rsp_ch returns tokens (protocol byte, host byte, port,
//   version, entry end with max age, status), with out_last on the final
//   token caused by an input byte. A byte may cause zero to three tokens.
//   csr_wr_en/csr_wr_data set the default max age; write only while idle.
// Timing and throughput:
//   The first token of a byte appears in the cycle after the byte is taken.
//   A byte is taken every cycle while each byte yields at most one token
//   and rsp_ch.ready is high; a byte yielding more tokens holds the result
//   register until its last token leaves, one per cycle while ready is high.
// Reset:
//   The parser returns to the start of a value and the default max age
//   returns to 86400. Pending tokens are dropped.
// Stalls:
//   When rsp_ch.ready is low, tokens hold and req_ch.ready drops until the
//   last token of the current byte is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module alt_svc_header_parser (
   input  logic        clock,
   input  logic        reset,
   ash_req_if.sink     req_ch,
   ash_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import ash_pkg::*;

`include "alt_svc_header_parser_assert.svh"

   state_type  state_ff, state_in;
   logic [31:0] max_age_ff;
   result_type step_res;
   logic       can_load;
   logic       accept;

   assign req_ch.ready = can_load;
   assign accept = req_ch.valid && req_ch.ready;

   // Byte step logic.
   ash_step u_step (
      .state_cur       (state_ff),
      .in_byte         (req_ch.in_byte),
      .in_last         (req_ch.in_last),
      .default_max_age (max_age_ff),
      .state_nxt       (state_in),
      .result          (step_res)
   );

   // Token output register.
   ash_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (step_res),
      .can_load  (can_load),
      .rsp_ch    (rsp_ch)
   );

   // Parser state and the default max age register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= STATE_RESET;
         max_age_ff <= DEFAULT_MAX_AGE;
      end else begin
         if (accept) state_ff <= state_in;
         if (csr_wr_en) max_age_ff <= csr_wr_data;
      end
   end

   // A stalled token blocks new bytes.
   `ASH_ASSERT_SAME(a_stall_blocks, clock, reset, rsp_ch.valid && !rsp_ch.ready, !req_ch.ready, "byte taken while tokens stall")
   // The final byte of a value returns the parser to its start.
   `ASH_ASSERT_NEXT(a_last_resets, clock, reset, accept && req_ch.in_last, state_ff.phase == PH_PROTO_START && !state_ff.err, "parser not back at start after final byte")
   // Bytes after an error give no tokens until the final byte.
   `ASH_ASSERT_NEXT(a_err_silent, clock, reset, accept && state_ff.err && !req_ch.in_last, !rsp_ch.valid, "token emitted after error")

endmodule

`default_nettype wire
